// ===== hw/rtl/bracket_nesting_checker_assert.svh =====
// Assertion macros for the checker file bnc_checker.sv.
`ifndef BRACKET_NESTING_CHECKER_ASSERT_SVH
`define BRACKET_NESTING_CHECKER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BNC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bracket checker assertion failed");

// Next-cycle implication, off during reset.
`define BNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bracket checker assertion failed");

`endif

// ===== hw/rtl/bnc_pkg.sv =====
package bnc_pkg;

  localparam int CHAR_W     = 8;
  localparam int PTS_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int SCORE_W    = 64;
  localparam int TOTAL_W    = 32;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_KINDS  = 4;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [PTS_W-1:0] POINTS_ROUND_RST  = 16'd3;
  localparam logic [PTS_W-1:0] POINTS_SQUARE_RST = 16'd57;
  localparam logic [PTS_W-1:0] POINTS_CURLY_RST  = 16'd1197;
  localparam logic [PTS_W-1:0] POINTS_ANGLE_RST  = 16'd25137;

  localparam logic [CFG_IDX_W-1:0] REG_POINTS_ROUND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_SQUARE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_CURLY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_ANGLE  = 3'd3;

  localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE   = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;

  typedef enum logic [1:0] {
    KIND_ROUND,
    KIND_SQUARE,
    KIND_CURLY,
    KIND_ANGLE
  } kind_e;

  typedef enum logic [1:0] {
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OTHER
  } cls_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_BALANCED,
    ST_INCOMPLETE,
    ST_CORRUPTED,
    ST_UNDERFLOW,
    ST_OVERFLOW
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_WRAP,
    BK_SCORE_RD,
    BK_SCORE_ACC,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    cls_e  cls;
    kind_e kind;
    logic  last;
  } op_t;

endpackage

// ===== hw/rtl/bnc_in_if.sv =====
interface bnc_in_if;
  import bnc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink (input valid, input char_code, input line_end, output ready);
endinterface

// ===== hw/rtl/bnc_out_if.sv =====
interface bnc_out_if;
  import bnc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] line_status;
  logic [PTS_W-1:0]    error_points;
  logic [SCORE_W-1:0]  completion_score;
  logic [TOTAL_W-1:0]  total_points;
  logic [COUNT_W-1:0]  open_count;

  modport source (
    output valid, output line_status, output error_points, output completion_score,
    output total_points, output open_count, input ready
  );
  modport sink (
    input valid, input line_status, input error_points, input completion_score,
    input total_points, input open_count, output ready
  );
endinterface

// ===== hw/rtl/bnc_front.sv =====
module bnc_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  bnc_in_if.sink       in_ch,
  output logic         op_valid_o,
  output bnc_pkg::op_t op_o,
  input  logic         op_ready_i
);
  import bnc_pkg::*;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;
  op_t               op_in;

  function automatic op_t classify(logic [CHAR_W-1:0] c, logic last);
    op_t op;
    op.last = last;
    op.kind = KIND_ROUND;
    op.cls  = CLS_OTHER;
    unique case (c)
      CH_OPEN_ROUND:   begin op.cls = CLS_OPEN;  op.kind = KIND_ROUND;  end
      CH_OPEN_SQUARE:  begin op.cls = CLS_OPEN;  op.kind = KIND_SQUARE; end
      CH_OPEN_CURLY:   begin op.cls = CLS_OPEN;  op.kind = KIND_CURLY;  end
      CH_OPEN_ANGLE:   begin op.cls = CLS_OPEN;  op.kind = KIND_ANGLE;  end
      CH_CLOSE_ROUND:  begin op.cls = CLS_CLOSE; op.kind = KIND_ROUND;  end
      CH_CLOSE_SQUARE: begin op.cls = CLS_CLOSE; op.kind = KIND_SQUARE; end
      CH_CLOSE_CURLY:  begin op.cls = CLS_CLOSE; op.kind = KIND_CURLY;  end
      CH_CLOSE_ANGLE:  begin op.cls = CLS_CLOSE; op.kind = KIND_ANGLE;  end
      default: begin
        op.cls = CLS_OTHER;
      end
    endcase
    return op;
  endfunction

  assign op_in       = classify(in_ch.char_code, in_ch.line_end);
  assign in_ch.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign op_valid_o  = (count_q != '0);
  assign op_o        = queue_q[rd_ptr_q];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

// ===== hw/rtl/bnc_back.sv =====
module bnc_back #(
  parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           op_valid_i,
  input  bnc_pkg::op_t                   op_i,
  output logic                           op_ready_o,
  bnc_out_if.source                      out_ch
);
  import bnc_pkg::*;

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

  kind_e              stack_mem [STACK_DEPTH];
  kind_e              rd_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;

  back_state_e        state_q, state_d;
  logic [PTS_W-1:0]   points_q [NUM_KINDS];
  logic [LVL_W-1:0]   level_q, level_d;
  status_e            verdict_q, verdict_d;
  logic [PTS_W-1:0]   held_q, held_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  op_t                op_q, op_d;
  logic [IDX_W-1:0]   sweep_q, sweep_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic               out_load;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [PTS_W-1:0]    out_points_q;
  logic [SCORE_W-1:0]  out_score_q;
  logic [TOTAL_W-1:0]  out_total_q;
  logic [COUNT_W-1:0]  out_count_q;
  status_e             line_status;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (op_valid_i) begin
          if (verdict_q == ST_BALANCED && op_i.cls != CLS_OPEN && level_q != '0) begin
            state_d = BK_CHECK;
          end else if (op_i.last) begin
            state_d = BK_WRAP;
          end
        end
      end
      BK_CHECK: state_d = op_q.last ? BK_WRAP : BK_IDLE;
      BK_WRAP: begin
        state_d = (verdict_q == ST_BALANCED && level_q != '0) ? BK_SCORE_RD : BK_EMIT;
      end
      BK_SCORE_RD:  state_d = BK_SCORE_ACC;
      BK_SCORE_ACC: state_d = (sweep_q == '0) ? BK_EMIT : BK_SCORE_RD;
      BK_EMIT:      state_d = out_load ? BK_IDLE : BK_EMIT;
      default:      state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    op_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = IDX_W'(level_q);
    mem_raddr  = IDX_W'(level_q - LVL_W'(1));
    level_d    = level_q;
    verdict_d  = verdict_q;
    held_d     = held_q;
    total_d    = total_q;
    op_d       = op_q;
    sweep_d    = sweep_q;
    score_d    = score_q;
    out_load   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        op_ready_o = 1'b1;
        if (op_valid_i) begin
          op_d = op_i;
          if (verdict_q == ST_BALANCED) begin
            if (op_i.cls == CLS_OPEN) begin
              if (level_q == LVL_FULL) begin
                verdict_d = ST_OVERFLOW;
              end else begin
                mem_we  = 1'b1;
                level_d = level_q + LVL_W'(1);
              end
            end else if (level_q == '0) begin
              verdict_d = ST_UNDERFLOW;
            end
          end
        end
      end
      BK_CHECK: begin
        if (op_q.cls == CLS_CLOSE && op_q.kind == rd_q) begin
          level_d = level_q - LVL_W'(1);
        end else begin
          verdict_d = ST_CORRUPTED;
          held_d    = (op_q.cls == CLS_CLOSE) ? points_q[op_q.kind] : '0;
        end
      end
      BK_WRAP: begin
        score_d = '0;
        sweep_d = IDX_W'(level_q - LVL_W'(1));
      end
      BK_SCORE_RD: begin
        mem_raddr = sweep_q;
      end
      BK_SCORE_ACC: begin
        score_d = (score_q << 2) + score_q + SCORE_W'(rd_q) + SCORE_W'(1);
        if (sweep_q != '0) begin
          sweep_d = sweep_q - IDX_W'(1);
        end
      end
      BK_EMIT: begin
        out_load = !out_valid_q || out_ch.ready;
        if (out_load) begin
          total_d   = total_q + TOTAL_W'(held_q);
          level_d   = '0;
          verdict_d = ST_BALANCED;
          held_d    = '0;
        end
      end
      default: begin
        op_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (verdict_q != ST_BALANCED) begin
      line_status = verdict_q;
    end else if (level_q == '0) begin
      line_status = ST_BALANCED;
    end else begin
      line_status = ST_INCOMPLETE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      level_q     <= '0;
      verdict_q   <= ST_BALANCED;
      held_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      points_q[KIND_ROUND]  <= POINTS_ROUND_RST;
      points_q[KIND_SQUARE] <= POINTS_SQUARE_RST;
      points_q[KIND_CURLY]  <= POINTS_CURLY_RST;
      points_q[KIND_ANGLE]  <= POINTS_ANGLE_RST;
    end else begin
      state_q   <= state_d;
      level_q   <= level_d;
      verdict_q <= verdict_d;
      held_q    <= held_d;
      total_q   <= total_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_POINTS_ROUND:  points_q[KIND_ROUND]  <= cfg_data_i;
          REG_POINTS_SQUARE: points_q[KIND_SQUARE] <= cfg_data_i;
          REG_POINTS_CURLY:  points_q[KIND_CURLY]  <= cfg_data_i;
          REG_POINTS_ANGLE:  points_q[KIND_ANGLE]  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    sweep_q <= sweep_d;
    score_q <= score_d;
    if (out_load) begin
      out_status_q <= line_status;
      out_points_q <= held_q;
      out_score_q  <= (verdict_q == ST_BALANCED) ? score_q : '0;
      out_total_q  <= total_q + TOTAL_W'(held_q);
      out_count_q  <= COUNT_W'(level_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= op_i.kind;
    end
    rd_q <= stack_mem[mem_raddr];
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.line_status      = out_status_q;
  assign out_ch.error_points     = out_points_q;
  assign out_ch.completion_score = out_score_q;
  assign out_ch.total_points     = out_total_q;
  assign out_ch.open_count       = out_count_q;

endmodule

// ===== hw/rtl/bracket_nesting_checker.sv =====
// Bracket nesting checker.
// in_ch takes one character a beat with a last-of-line flag; out_ch gives one
// beat per line: status, error points, completion score, running point total
// and open bracket count. cfg_we_i, cfg_idx_i and cfg_data_i write the point
// registers; indexes past 3 are dropped. The user must write them only while
// the block is idle; the block itself leaves this unchecked. A four-entry
// queue decouples character intake from the stack engine, so in_ch takes a
// beat a cycle until the queue fills. The stack engine pushes an opener while
// idle; a closer or other character on a balanced line with open entries adds
// a check state that reads the stack top. A line end adds a wrap-up state, a
// read and an accumulate state per open bracket for the score sweep, and an
// emit state that loads the output register. Reset empties the queue, clears
// line state and the point total, and restores the default point values; stack
// memory is not cleared. A stalled out_ch holds its beat; the engine waits on
// the next line end while the queue keeps taking characters until full.
module bracket_nesting_checker #(
  parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bnc_in_if.sink                         in_ch,
  bnc_out_if.source                      out_ch
);
  import bnc_pkg::*;

  logic op_valid;
  logic op_ready;
  op_t  op;

  bnc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_ready_i (op_ready)
  );

  bnc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .out_ch     (out_ch)
  );

endmodule

// ===== hw/rtl/bnc_checker.sv =====
`include "bracket_nesting_checker_assert.svh"

module bnc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [bnc_pkg::STATUS_W-1:0]  line_status_i,
  input logic [bnc_pkg::SCORE_W-1:0]   completion_score_i,
  input logic [bnc_pkg::TOTAL_W-1:0]   total_points_i,
  input logic [bnc_pkg::COUNT_W-1:0]   open_count_i
);
  import bnc_pkg::*;

  `BNC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `BNC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(total_points_i) && $stable(completion_score_i) && $stable(line_status_i))
  `BNC_ASSERT_IMPLIES(a_err_no_score, clk_i, rst_ni, out_valid_i && (line_status_i == ST_CORRUPTED || line_status_i == ST_UNDERFLOW || line_status_i == ST_OVERFLOW), completion_score_i == '0)
  `BNC_ASSERT_IMPLIES(a_balanced_empty, clk_i, rst_ni, out_valid_i && line_status_i == ST_BALANCED, open_count_i == '0 && completion_score_i == '0)

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_ch.valid),
  .out_ready_i        (out_ch.ready),
  .line_status_i      (out_ch.line_status),
  .completion_score_i (out_ch.completion_score),
  .total_points_i     (out_ch.total_points),
  .open_count_i       (out_ch.open_count)
);

// ===== tb/sv/bracket_nesting_checker_tb.sv =====
`timescale 1ns / 100ps

module bracket_nesting_checker_tb;
  import bnc_pkg::*;

  localparam int DEPTH         = STACK_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 40;
  localparam int PHASE_CHARS   = 125;

  typedef struct packed {
    status_e              status;
    logic [PTS_W-1:0]     points;
    logic [SCORE_W-1:0]   score;
    logic [TOTAL_W-1:0]   total;
    logic [COUNT_W-1:0]   count;
  } line_report_t;

  localparam line_report_t NO_REPORT = '{status: ST_BALANCED, default: '0};

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    int unsigned       rep;
    bit                typed;
    line_report_t      want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bnc_in_if  in_ch ();
  bnc_out_if out_ch ();

  bracket_nesting_checker #(
    .STACK_DEPTH (DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // bracket state as the block should hold it
  logic [PTS_W-1:0]   points_of [NUM_KINDS];
  kind_e              open_kinds [DEPTH];
  int                 open_depth;
  bit                 line_bad;
  status_e            bad_status;
  logic [PTS_W-1:0]   held_points;
  logic [TOTAL_W-1:0] points_sum;

  line_report_t pending_reports [$];
  stim_row_t    script [$];
  int unsigned  mismatches;
  int unsigned  chars_sent;
  bit           feed_calm;
  bit           drain_calm;

  function automatic logic [CHAR_W-1:0] open_code(input kind_e k);
    case (k)
      KIND_ROUND:  return CH_OPEN_ROUND;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      KIND_CURLY:  return CH_OPEN_CURLY;
      default:     return CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] close_code(input kind_e k);
    case (k)
      KIND_ROUND:  return CH_CLOSE_ROUND;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      KIND_CURLY:  return CH_CLOSE_CURLY;
      default:     return CH_CLOSE_ANGLE;
    endcase
  endfunction

  function automatic bit decode_open(input logic [CHAR_W-1:0] ch, output kind_e k);
    k = KIND_ROUND;
    case (ch)
      CH_OPEN_ROUND:  k = KIND_ROUND;
      CH_OPEN_SQUARE: k = KIND_SQUARE;
      CH_OPEN_CURLY:  k = KIND_CURLY;
      CH_OPEN_ANGLE:  k = KIND_ANGLE;
      default:        return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit decode_close(input logic [CHAR_W-1:0] ch, output kind_e k);
    k = KIND_ROUND;
    case (ch)
      CH_CLOSE_ROUND:  k = KIND_ROUND;
      CH_CLOSE_SQUARE: k = KIND_SQUARE;
      CH_CLOSE_CURLY:  k = KIND_CURLY;
      CH_CLOSE_ANGLE:  k = KIND_ANGLE;
      default:         return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit track_char(input logic [CHAR_W-1:0] ch, input logic last,
                                    output line_report_t rep);
    kind_e              ok;
    kind_e              ck;
    bit                 is_open;
    bit                 is_close;
    logic [SCORE_W-1:0] score;
    is_open  = decode_open(ch, ok);
    is_close = decode_close(ch, ck);
    rep      = NO_REPORT;
    score    = '0;
    if (!line_bad) begin
      if (is_open) begin
        if (open_depth >= DEPTH) begin
          line_bad   = 1'b1;
          bad_status = ST_OVERFLOW;
        end else begin
          open_kinds[open_depth] = ok;
          open_depth++;
        end
      end else if (open_depth == 0) begin
        line_bad   = 1'b1;
        bad_status = ST_UNDERFLOW;
      end else if (is_close && ck == open_kinds[open_depth-1]) begin
        open_depth--;
      end else begin
        line_bad    = 1'b1;
        bad_status  = ST_CORRUPTED;
        held_points = is_close ? points_of[ck] : '0;
      end
    end
    if (!last) return 1'b0;
    if (line_bad) begin
      rep.status = bad_status;
    end else begin
      rep.status = (open_depth == 0) ? ST_BALANCED : ST_INCOMPLETE;
      for (int i = open_depth - 1; i >= 0; i--) begin
        score = score * 64'd5 + 64'(open_kinds[i]) + 64'd1;
      end
    end
    points_sum += 32'(held_points);
    rep.points = held_points;
    rep.score  = score;
    rep.total  = points_sum;
    rep.count  = COUNT_W'(open_depth);
    open_depth  = 0;
    line_bad    = 1'b0;
    held_points = '0;
    return 1'b1;
  endfunction

  task automatic flag(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  task automatic check_report(input line_report_t got);
    line_report_t want;
    if (pending_reports.size() == 0) begin
      flag($sformatf("line report with none pending, status %0d", got.status));
      return;
    end
    want = pending_reports.pop_front();
    if (got.status !== want.status)
      flag($sformatf("line_status %0d, want %0d", got.status, want.status));
    if (got.points !== want.points)
      flag($sformatf("error_points %0d, want %0d", got.points, want.points));
    if (got.score !== want.score)
      flag($sformatf("completion_score %0h, want %0h", got.score, want.score));
    if (got.total !== want.total)
      flag($sformatf("total_points %0d, want %0d", got.total, want.total));
    if (got.count !== want.count)
      flag($sformatf("open_count %0d, want %0d", got.count, want.count));
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last,
                           input bit typed = 1'b0, input line_report_t want = NO_REPORT);
    int unsigned  gap;
    line_report_t rep;
    if ($urandom_range(0, 15) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= ch;
    in_ch.line_end  <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (track_char(ch, last, rep)) begin
      pending_reports.insert(pending_reports.size(), typed ? want : rep);
    end
    chars_sent++;
  endtask

  task automatic send_line();
    logic [CHAR_W-1:0] chars [$];
    kind_e             opened [$];
    kind_e             k;
    int unsigned       pick;
    int unsigned       len;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(1, 10);
    if (pick < 5) begin
      repeat ($urandom_range(26, 34)) begin
        chars.insert(chars.size(), open_code(kind_e'($urandom_range(0, 3))));
      end
    end else if (pick < 17) begin
      repeat (len) chars.insert(chars.size(), 8'($urandom));
    end else begin
      for (int i = 0; i < len; i++) begin
        if (opened.size() == 0 || $urandom_range(0, 1) == 1) begin
          k = kind_e'($urandom_range(0, 3));
          opened.insert(opened.size(), k);
          chars.insert(chars.size(), open_code(k));
        end else begin
          chars.insert(chars.size(), close_code(opened.pop_back()));
        end
      end
      if (pick < 60) begin
        while (opened.size() != 0) chars.insert(chars.size(), close_code(opened.pop_back()));
      end
      if (pick >= 80) begin
        chars[$urandom_range(0, chars.size() - 1)] = ($urandom_range(0, 1) == 1) ?
          close_code(kind_e'($urandom_range(0, 3))) : 8'($urandom);
      end
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx <= REG_POINTS_ANGLE) points_of[idx[1:0]] = val;
  endtask

  task automatic load_points(input logic [PTS_W-1:0] p_round, p_square, p_curly, p_angle);
    write_reg(REG_POINTS_ROUND, p_round);
    write_reg(REG_POINTS_SQUARE, p_square);
    write_reg(REG_POINTS_CURLY, p_curly);
    write_reg(REG_POINTS_ANGLE, p_angle);
    write_reg(CFG_IDX_W'($urandom_range(4, 7)), 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_chars(input logic [CHAR_W-1:0] ch, input int unsigned rep = 1,
                           input logic last = 1'b0);
    stim_row_t row;
    row = '{ch: ch, last: last, rep: rep, typed: 1'b0, want: NO_REPORT};
    script.insert(script.size(), row);
  endtask

  task automatic add_line_end(input logic [CHAR_W-1:0] ch, input status_e st,
                              input logic [PTS_W-1:0] pts, input logic [SCORE_W-1:0] score,
                              input logic [TOTAL_W-1:0] total, input logic [COUNT_W-1:0] cnt);
    line_report_t want;
    stim_row_t    row;
    want = '{status: st, points: pts, score: score, total: total, count: cnt};
    row  = '{ch: ch, last: 1'b1, rep: 1, typed: 1'b1, want: want};
    script.insert(script.size(), row);
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    line_report_t got;
    int unsigned  stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) drain_calm = !drain_calm;
      stall = drain_calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      got.status = status_e'(out_ch.line_status);
      got.points = out_ch.error_points;
      got.score  = out_ch.completion_score;
      got.total  = out_ch.total_points;
      got.count  = out_ch.open_count;
      check_report(got);
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.line_end  <= 1'b0;
    points_of[KIND_ROUND]  = POINTS_ROUND_RST;
    points_of[KIND_SQUARE] = POINTS_SQUARE_RST;
    points_of[KIND_CURLY]  = POINTS_CURLY_RST;
    points_of[KIND_ANGLE]  = POINTS_ANGLE_RST;
    open_depth  = 0;
    line_bad    = 1'b0;
    bad_status  = ST_BALANCED;
    held_points = '0;
    points_sum  = '0;
    mismatches  = 0;
    chars_sent  = 0;
    feed_calm   = 1'b0;
    drain_calm  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_line_end(CH_CLOSE_ROUND, ST_UNDERFLOW, 0, 0, 0, 0);
    add_chars(CH_OPEN_ROUND);
    add_line_end(CH_CLOSE_SQUARE, ST_CORRUPTED, 57, 0, 57, 1);
    add_chars(CH_OPEN_SQUARE);
    add_line_end(CH_CLOSE_CURLY, ST_CORRUPTED, 1197, 0, 1254, 1);
    add_chars(CH_OPEN_CURLY);
    add_line_end(CH_CLOSE_ANGLE, ST_CORRUPTED, 25137, 0, 26391, 1);
    add_chars(CH_OPEN_ANGLE);
    add_line_end(CH_CLOSE_ROUND, ST_CORRUPTED, 3, 0, 26394, 1);
    add_chars(CH_OPEN_ANGLE);
    add_line_end(8'h00, ST_CORRUPTED, 0, 0, 26394, 1);
    add_chars(CH_OPEN_ROUND);
    add_chars(CH_OPEN_SQUARE);
    add_chars(CH_OPEN_CURLY);
    add_chars(CH_OPEN_ANGLE);
    add_chars(CH_CLOSE_ANGLE);
    add_chars(CH_CLOSE_CURLY);
    add_chars(CH_CLOSE_SQUARE);
    add_line_end(CH_CLOSE_ROUND, ST_BALANCED, 0, 0, 26394, 0);
    add_chars(CH_OPEN_ROUND);
    add_chars(CH_OPEN_SQUARE);
    add_chars(CH_OPEN_CURLY);
    add_line_end(CH_OPEN_ANGLE, ST_INCOMPLETE, 0, 586, 26394, 4);
    add_line_end(8'hFF, ST_UNDERFLOW, 0, 0, 26394, 0);
    // rest of the line is dropped after the first mismatch
    add_chars(CH_OPEN_ROUND);
    add_chars(CH_CLOSE_SQUARE);
    add_chars(CH_OPEN_SQUARE);
    add_line_end(CH_CLOSE_ROUND, ST_CORRUPTED, 57, 0, 26451, 1);
    add_line_end(CH_OPEN_ROUND, ST_INCOMPLETE, 0, 1, 26451, 1);
    add_chars(CH_OPEN_ANGLE, DEPTH);
    add_line_end(CH_OPEN_ROUND, ST_OVERFLOW, 0, 0, 26451, DEPTH);
    add_chars(CH_OPEN_CURLY, DEPTH - 1);
    add_chars(CH_OPEN_CURLY, 1, 1'b1);

    foreach (script[r]) begin
      repeat (script[r].rep) send_char(script[r].ch, script[r].last, script[r].typed,
                                       script[r].want);
    end
    in_ch.valid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       load_points('0, '0, '0, '0);
        2:       load_points('1, '1, '1, '1);
        default: load_points(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      chars_sent = 0;
      while (chars_sent < PHASE_CHARS) send_line();
      in_ch.valid <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
